FILE: rtl/fr_pkg.sv
// Shared types, codes and widths for the fragment reassembler.
package fr_pkg;

  localparam int MAX_MESSAGE_DEF = 4096;
  localparam int BYTE_W          = 8;
  localparam int STORE_AW        = 12;
  localparam int MSG_LEN_W       = 13;
  localparam int STATUS_W        = 3;

  // header byte positions, then payload phase
  localparam logic [2:0] POS_TAG     = 3'd0;
  localparam logic [2:0] POS_SEQ_HI  = 3'd1;
  localparam logic [2:0] POS_SEQ_LO  = 3'd2;
  localparam logic [2:0] POS_LEN_HI  = 3'd3;
  localparam logic [2:0] POS_LEN_LO  = 3'd4;
  localparam logic [2:0] POS_PAYLOAD = 3'd5;

  localparam logic [STATUS_W-1:0] ST_PENDING   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPLETE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FRAMING   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

  typedef enum logic [1:0] {
    V_OK    = 2'd0,
    V_START = 2'd1,
    V_FRAME = 2'd2,
    V_BIG   = 2'd3
  } verdict_t;

  typedef struct packed {
    logic                cmd;
    logic [BYTE_W-1:0]   data_byte;
    logic                packet_end;
    logic [STORE_AW-1:0] read_index;
  } fr_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [MSG_LEN_W-1:0] msg_len;
    logic [BYTE_W-1:0]    msg_tag;
    logic [BYTE_W-1:0]    read_byte;
  } fr_out_t;

  // result produced by the parser for one accepted item
  typedef struct packed {
    logic                 valid;
    logic [STATUS_W-1:0]  status;
    logic [MSG_LEN_W-1:0] msg_len;
    logic [BYTE_W-1:0]    msg_tag;
  } fr_res_t;

  // store write request
  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [BYTE_W-1:0]   data;
  } fr_wr_t;

endpackage

FILE: rtl/fr_store.sv
// Message byte store: one write port, one registered read port.
module fr_store (
  input  logic                       clk,
  input  fr_pkg::fr_wr_t             wr,
  input  logic                       rd_en,
  input  logic [fr_pkg::STORE_AW-1:0] rd_addr,
  output logic [fr_pkg::BYTE_W-1:0]   rd_data_r
);
  import fr_pkg::*;

  localparam int DEPTH = 1 << STORE_AW;

  logic [BYTE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/fr_parser.sv
// Header parser, sequence check and message bookkeeping.
module fr_parser #(
  parameter int MAX_MESSAGE = fr_pkg::MAX_MESSAGE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  fr_pkg::fr_in_t  in_item,
  output fr_pkg::fr_res_t res,
  output fr_pkg::fr_wr_t  wr
);
  import fr_pkg::*;

  localparam int LEN_W = $clog2(MAX_MESSAGE + 1);

  logic [15:0]       exp_r, exp_nxt;
  logic [LEN_W-1:0]  total_len_r, total_len_nxt;
  logic [LEN_W-1:0]  filled_len_r, filled_len_nxt;
  logic [BYTE_W-1:0] saved_tag_r, saved_tag_nxt;
  logic [2:0]        pos_r, pos_nxt;
  logic [BYTE_W-1:0] header_high_r, header_high_nxt;
  verdict_t          verdict_r, verdict_nxt;

  logic              pkt;
  logic              hi_ok;
  logic [15:0]       total;
  logic [BYTE_W-1:0] b;

  assign pkt   = acc && !in_item.cmd;
  assign b     = in_item.data_byte;
  assign total = {header_high_r, b};
  assign hi_ok = (verdict_r == V_OK) ||
                 ((verdict_r == V_START) && (exp_r[15:8] == '0));

  always_comb begin
    exp_nxt         = exp_r;
    total_len_nxt   = total_len_r;
    filled_len_nxt  = filled_len_r;
    saved_tag_nxt   = saved_tag_r;
    pos_nxt         = pos_r;
    header_high_nxt = header_high_r;
    verdict_nxt     = verdict_r;
    wr              = '0;
    res             = '0;

    if (acc && in_item.cmd) begin
      res.valid  = 1'b1;
      res.status = ST_READ;
    end else if (pkt) begin
      case (pos_r)
        POS_TAG: begin
          header_high_nxt = b;
          pos_nxt         = POS_SEQ_HI;
        end
        POS_SEQ_HI: begin
          if (b == '0) begin
            verdict_nxt = V_START;
          end else if (b == exp_r[15:8]) begin
            verdict_nxt = V_OK;
          end else begin
            verdict_nxt = V_FRAME;
          end
          pos_nxt = POS_SEQ_LO;
        end
        POS_SEQ_LO: begin
          if ((verdict_r == V_START) && (b == '0)) begin
            saved_tag_nxt = header_high_r;
            pos_nxt       = POS_LEN_HI;
          end else begin
            if (hi_ok && (exp_r != '0) && (exp_r[7:0] == b)) begin
              verdict_nxt = V_OK;
              exp_nxt     = exp_r + 16'd1;
            end else begin
              verdict_nxt = V_FRAME;
            end
            pos_nxt = POS_PAYLOAD;
          end
        end
        POS_LEN_HI: begin
          header_high_nxt = b;
          pos_nxt         = POS_LEN_LO;
        end
        POS_LEN_LO: begin
          if ({1'b0, total} > 17'(MAX_MESSAGE)) begin
            verdict_nxt = V_BIG;
          end else begin
            total_len_nxt  = LEN_W'(total);
            filled_len_nxt = '0;
            exp_nxt        = 16'd1;
            verdict_nxt    = V_OK;
          end
          pos_nxt = POS_PAYLOAD;
        end
        default: begin
          if ((verdict_r == V_OK) && (filled_len_r < total_len_r)) begin
            wr.en          = 1'b1;
            wr.addr        = STORE_AW'(filled_len_r);
            wr.data        = b;
            filled_len_nxt = filled_len_r + LEN_W'(1);
          end
          pos_nxt = POS_PAYLOAD;
        end
      endcase

      if (in_item.packet_end) begin
        res.valid = 1'b1;
        // too few header bytes, bad sequence or unfinished opening header
        if ((pos_r < POS_SEQ_LO) || (verdict_nxt == V_FRAME) ||
            (verdict_nxt == V_START)) begin
          res.status     = ST_FRAMING;
          exp_nxt        = '0;
          total_len_nxt  = '0;
          filled_len_nxt = '0;
          saved_tag_nxt  = '0;
        end else if (verdict_nxt == V_BIG) begin
          res.status     = ST_TOO_LARGE;
          exp_nxt        = '0;
          total_len_nxt  = '0;
          filled_len_nxt = '0;
          saved_tag_nxt  = '0;
        end else if (filled_len_nxt >= total_len_nxt) begin
          res.status  = ST_COMPLETE;
          res.msg_len = MSG_LEN_W'(total_len_nxt);
          res.msg_tag = saved_tag_nxt;
          exp_nxt     = '0;
        end else begin
          res.status = ST_PENDING;
        end
        pos_nxt         = POS_TAG;
        header_high_nxt = '0;
        verdict_nxt     = V_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r         <= '0;
      total_len_r   <= '0;
      filled_len_r  <= '0;
      saved_tag_r   <= '0;
      pos_r         <= POS_TAG;
      header_high_r <= '0;
      verdict_r     <= V_OK;
    end else begin
      exp_r         <= exp_nxt;
      total_len_r   <= total_len_nxt;
      filled_len_r  <= filled_len_nxt;
      saved_tag_r   <= saved_tag_nxt;
      pos_r         <= pos_nxt;
      header_high_r <= header_high_nxt;
      verdict_r     <= verdict_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    filled_len_r <= total_len_r)
    else $error("filled length passed message total");

  a_packet_end_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    pkt && in_item.packet_end |=> (pos_r == POS_TAG) && (verdict_r == V_OK))
    else $error("parser not rearmed after packet end");

  a_error_drops: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && ((res.status == ST_FRAMING) || (res.status == ST_TOO_LARGE))
    |=> (exp_r == '0) && (filled_len_r == '0) && (total_len_r == '0))
    else $error("message state kept after error");

  a_complete_closes: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && (res.status == ST_COMPLETE) |=> exp_r == '0)
    else $error("message still open after completion");

endmodule

FILE: rtl/fragment_reassembler.sv
// Top level of the fragment reassembler: parser, byte store and result stages.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+------------------------------------------
//   in      | in  | in_valid/in_stall  | cmd, data_byte, packet_end, read_index
//   out     | out | out_valid/out_stall| status, msg_len, msg_tag, read_byte
//
// One item is taken per cycle while the result path has room. A result passes
// through the holding stage, which waits for the synchronous store read, and
// then the output register. Header checks and the store write finish in the accept
// cycle, so a read that follows a write of the same byte sees the new data.
// rst_n is synchronous; it clears all message state, the store is not cleared.
// A stalled output holds; the holding stage then fills and only then in_stall
// rises.
module fragment_reassembler #(
  parameter int MAX_MESSAGE = fr_pkg::MAX_MESSAGE_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fr_pkg::fr_in_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output fr_pkg::fr_out_t out_item
);
  import fr_pkg::*;

  logic              acc;
  fr_res_t           res;
  fr_wr_t            wr;
  logic [BYTE_W-1:0] rd_data_r;

  // holding stage: waits for store read data
  logic    s1_valid_r, s1_valid_nxt;
  fr_res_t s1_res_r;
  logic    s1_adv;

  // output register
  logic    out_valid_r, out_valid_nxt;
  fr_out_t out_item_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign acc      = in_valid && !in_stall;

  fr_parser #(
    .MAX_MESSAGE (MAX_MESSAGE)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_item (in_item),
    .res     (res),
    .wr      (wr)
  );

  fr_store u_store (
    .clk       (clk),
    .wr        (wr),
    .rd_en     (acc && in_item.cmd),
    .rd_addr   (in_item.read_index),
    .rd_data_r (rd_data_r)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc && res.valid) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (acc && res.valid) begin
      s1_res_r <= res;
    end
    if (s1_adv) begin
      out_item_r.status    <= s1_res_r.status;
      out_item_r.msg_len   <= s1_res_r.msg_len;
      out_item_r.msg_tag   <= s1_res_r.msg_tag;
      out_item_r.read_byte <= (s1_res_r.status == ST_READ) ? rd_data_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty holding stage");

  a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !in_stall |=> out_valid_r)
    else $error("holding stage item lost");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && in_stall |=> s1_valid_r && $stable(s1_res_r))
    else $error("blocked holding stage changed");

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the fragment reassembler: packet framing, store and readback.
`timescale 1ns / 100ps

module testbench;
  import fr_pkg::*;

  localparam int GAP_MAX      = 4;     // longest sender gap, cycles
  localparam int RANDOM_ITEMS = 1500;  // size of the mixed random phase
  localparam int PRINT_CAP    = 40;    // mismatch lines printed before going quiet

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_stall;
  fr_in_t  in_item;
  logic    out_valid;
  logic    out_stall = 1'b0;
  fr_out_t out_item;

  fragment_reassembler u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // ---------------------------------------------------------------------------
  // Predicted block state. Mirrors the parser: header position, held byte,
  // running verdict for the current packet, and the open message bookkeeping.
  // ---------------------------------------------------------------------------
  logic [15:0] next_seq;       // sequence the next continuation must carry, 0 = none open
  logic [12:0] msg_total;
  logic [12:0] msg_filled;
  logic [7:0]  open_tag;
  logic [7:0]  hdr_hold;       // tag byte, later the high length byte
  logic [2:0]  hdr_pos;
  verdict_t    pkt_verdict;
  logic [7:0]  store_copy [0:4095];
  int          store_fill;     // entries [0, store_fill) have been written at least once

  fr_out_t     pending_reports [$];  // status reports owed by the block, oldest first
  logic [7:0]  pkt [$];              // bytes of the packet about to go out

  int fail_count;
  int items_sent;
  int burst_left;

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Far beyond the slowest legal run (a few thousand items, worst gaps and stalls).
  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: advances the state for one accepted item and queues the report
  // that item causes, if any.
  // ---------------------------------------------------------------------------
  function automatic void track_reassembly(input fr_in_t it);
    logic [2:0]  pos_before;
    logic [15:0] total;
    logic        hi_ok;
    logic [7:0]  b;
    fr_out_t     res;
    res = '0;
    b   = it.data_byte;

    // store readback, no effect on the parser
    if (it.cmd) begin
      res.status    = ST_READ;
      res.read_byte = store_copy[it.read_index];
      pending_reports.push_back(res);
      return;
    end

    pos_before = hdr_pos;
    case (hdr_pos)
      POS_TAG: begin
        hdr_hold = b;
        hdr_pos  = POS_SEQ_HI;
      end
      POS_SEQ_HI: begin
        // a zero high byte may still turn out to be an opening header
        if (b == 8'h00)
          pkt_verdict = V_START;
        else if (b == next_seq[15:8])
          pkt_verdict = V_OK;
        else
          pkt_verdict = V_FRAME;
        hdr_pos = POS_SEQ_LO;
      end
      POS_SEQ_LO: begin
        if (pkt_verdict == V_START && b == 8'h00) begin
          open_tag = hdr_hold;
          hdr_pos  = POS_LEN_HI;
        end else begin
          hi_ok = (pkt_verdict == V_OK) ||
                  (pkt_verdict == V_START && next_seq[15:8] == 8'h00);
          if (hi_ok && next_seq != 16'h0 && next_seq[7:0] == b) begin
            pkt_verdict = V_OK;
            next_seq    = next_seq + 16'd1;  // wraps to 0, closing the message
          end else begin
            pkt_verdict = V_FRAME;
          end
          hdr_pos = POS_PAYLOAD;
        end
      end
      POS_LEN_HI: begin
        hdr_hold = b;
        hdr_pos  = POS_LEN_LO;
      end
      POS_LEN_LO: begin
        total = {hdr_hold, b};
        if (total > MAX_MESSAGE_DEF) begin
          pkt_verdict = V_BIG;
        end else begin
          msg_total   = total[12:0];
          msg_filled  = '0;
          next_seq    = 16'd1;
          pkt_verdict = V_OK;
        end
        hdr_pos = POS_PAYLOAD;
      end
      default: begin
        // payload past the total is dropped
        if (pkt_verdict == V_OK && msg_filled < msg_total) begin
          store_copy[msg_filled[11:0]] = b;
          msg_filled = msg_filled + 13'd1;
          if (msg_filled > store_fill) store_fill = int'(msg_filled);
        end
        hdr_pos = POS_PAYLOAD;
      end
    endcase

    if (!it.packet_end) return;

    // packet end: short packet, bad sequence or a header left half done
    if (pos_before < POS_SEQ_LO || pkt_verdict == V_FRAME || pkt_verdict == V_START) begin
      res.status = ST_FRAMING;
    end else if (pkt_verdict == V_BIG) begin
      res.status = ST_TOO_LARGE;
    end else if (msg_filled >= msg_total) begin
      res.status  = ST_COMPLETE;
      res.msg_len = msg_total;
      res.msg_tag = open_tag;
      next_seq    = '0;
    end else begin
      res.status = ST_PENDING;
    end

    // both error kinds throw the open message away
    if (res.status == ST_FRAMING || res.status == ST_TOO_LARGE) begin
      next_seq   = '0;
      msg_total  = '0;
      msg_filled = '0;
      open_tag   = '0;
    end
    hdr_pos     = POS_TAG;
    hdr_hold    = '0;
    pkt_verdict = V_OK;
    pending_reports.push_back(res);
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders. Unused fields get random values so every bit toggles.
  // ---------------------------------------------------------------------------
  function automatic fr_in_t byte_item(input logic [7:0] b, input logic last);
    fr_in_t it;
    it.cmd        = 1'b0;
    it.data_byte  = b;
    it.packet_end = last;
    it.read_index = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic fr_in_t read_item(input int idx);
    fr_in_t it;
    it.cmd        = 1'b1;
    it.data_byte  = 8'($urandom_range(0, 255));
    it.packet_end = 1'($urandom_range(0, 1));
    it.read_index = idx[11:0];
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge. Works in bursts; between
  // bursts valid drops for a random number of cycles.
  // ---------------------------------------------------------------------------
  task automatic send_item(input fr_in_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, GAP_MAX)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 96)
                                               : $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(posedge clk);
    end while (in_stall);
    track_reassembly(it);
    burst_left--;
    items_sent++;
    @(negedge clk);
  endtask

  // Sends pkt with packet_end on its last byte; now and then a readback of a
  // written entry slips in between bytes, which must not disturb the parser.
  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) begin
      if (store_fill > 0 && $urandom_range(0, 29) == 0)
        send_item(read_item($urandom_range(0, store_fill - 1)));
      send_item(byte_item(pkt[i], i == pkt.size() - 1));
    end
  endtask

  task automatic add_payload(input int n);
    repeat (n) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  // Drop valid and wait for every owed report, then a few spare cycles.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall follows a 16-bit mask that is stepped through repeatedly and
  // redrawn whenever the phase counter wraps. Masks range from empty (free flow) to dense.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_mask  = '0;
  int          stall_phase = 0;

  always @(negedge clk) begin
    if (stall_phase == 0) begin
      case ($urandom_range(0, 3))
        0:       stall_mask = '0;
        1:       stall_mask = 16'($urandom);
        2:       stall_mask = 16'($urandom & $urandom);
        default: stall_mask = 16'($urandom | $urandom);
      endcase
    end
    out_stall   <= stall_mask[stall_phase[3:0]];
    stall_phase  = (stall_phase + 1) % 64;
  end

  // ---------------------------------------------------------------------------
  // Result check, field by field against the oldest owed report.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string field, input logic [12:0] got,
                                 input logic [12:0] want);
    fail_count++;
    if (fail_count <= PRINT_CAP)
      $display("ERROR %s: got %0h, expected %0h (items sent %0d)",
               field, got, want, items_sent);
  endtask

  always @(posedge clk) begin : check_results
    fr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("result with nothing owed, status", 13'(out_item.status), '0);
      end else begin
        want = pending_reports.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", 13'(out_item.status), 13'(want.status));
        if (out_item.msg_len !== want.msg_len)
          report_mismatch("msg_len", out_item.msg_len, want.msg_len);
        if (out_item.msg_tag !== want.msg_tag)
          report_mismatch("msg_tag", 13'(out_item.msg_tag), 13'(want.msg_tag));
        if (out_item.read_byte !== want.read_byte)
          report_mismatch("read_byte", 13'(out_item.read_byte), 13'(want.read_byte));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked corners: empty message, short packets, oversized total,
  // clipped payload, continuation with nothing open, readback.
  task automatic test_directed();
    pkt = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};   // total 0: complete at once
    send_packet();
    pkt = '{8'h00};                                // lone byte: framing
    send_packet();
    pkt = '{8'h11, 8'h00, 8'h00};                  // opening cut before length
    send_packet();
    pkt = '{8'h33, 8'h00, 8'h00, 8'hFF, 8'hFF};   // total 65535: too large
    send_packet();
    pkt = '{8'h5A, 8'h00, 8'h00, 8'h00, 8'h02, 8'hC3};  // total 2, one byte in
    send_packet();
    pkt = '{8'h01, 8'h00, 8'h01, 8'hFF, 8'h00};   // second byte beyond the total
    send_packet();
    pkt = '{8'h80, 8'h00, 8'h02};                  // message already closed
    send_packet();
    send_item(read_item(0));
    send_item(read_item(1));
    wait_quiet();
  endtask

  // Largest legal total opens and starts filling; one past it is too large
  // and throws the open message away.
  task automatic test_max_message();
    logic [7:0] tag;
    pkt = '{8'hA5, 8'h00, 8'h00, 8'h10, 8'h00};
    add_payload(100);
    send_packet();
    tag = 8'($urandom_range(0, 255));
    pkt = '{tag, 8'h00, 8'h01};
    add_payload(60);
    send_packet();
    pkt = '{tag, 8'h00, 8'h00, 8'h10, 8'h01};
    send_packet();
    send_item(read_item(0));
    send_item(read_item(159));
    send_item(read_item(80));
    wait_quiet();
  endtask

  // One message split into packets with random content. Sometimes it goes
  // wrong on purpose: bad sequence, cut packet, or simply abandoned.
  task automatic send_message(input logic [15:0] total);
    logic [15:0] seq;
    logic [7:0]  tag;
    int          left;
    int          chunk;
    tag   = 8'($urandom_range(0, 255));
    pkt   = '{tag, 8'h00, 8'h00, total[15:8], total[7:0]};
    left  = int'(total);
    chunk = $urandom_range(0, (left < 12) ? left : 12);
    add_payload(chunk);
    left -= chunk;
    if (left == 0 && $urandom_range(0, 3) == 0) add_payload($urandom_range(1, 3));
    send_packet();
    seq = 16'd1;
    while (left > 0) begin
      tag = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 39))
        0, 1, 2: begin
          seq = seq + 16'($urandom_range(1, 65535));  // never the expected value
          pkt = '{tag, seq[15:8], seq[7:0]};
          add_payload($urandom_range(0, 4));
          send_packet();
          return;
        end
        3: begin
          pkt = '{tag};
          if ($urandom_range(0, 1) == 1) pkt.push_back(seq[15:8]);
          send_packet();
          return;
        end
        4: return;
        default: ;
      endcase
      chunk = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, (left < 24) ? left : 24);
      pkt   = '{tag, seq[15:8], seq[7:0]};
      add_payload(chunk);
      left -= chunk;
      if (left == 0 && $urandom_range(0, 3) == 0) add_payload($urandom_range(1, 3));
      send_packet();
      seq++;
    end
  endtask

  // Mostly well-formed messages of small size, mixed with readback, random
  // byte noise and oversized openings.
  task automatic test_random();
    logic [15:0] total;
    logic [7:0]  tag;
    int          start;
    int          pick;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        pick  = $urandom_range(0, 19);
        total = (pick < 14) ? 16'($urandom_range(0, 24)) :
                (pick < 19) ? 16'($urandom_range(25, 200)) : 16'($urandom_range(201, 700));
        send_message(total);
      end else if (pick < 72) begin
        repeat ($urandom_range(1, 4))
          send_item(read_item($urandom_range(0, store_fill - 1)));
      end else if (pick < 88) begin
        pkt.delete();
        add_payload($urandom_range(1, 8));
        if (pkt.size() > 1 && $urandom_range(0, 1) == 1) pkt[1] = 8'h00;
        send_packet();
      end else begin
        total = ($urandom_range(0, 7) == 0) ? 16'd4097 : 16'($urandom_range(4097, 65535));
        tag   = 8'($urandom_range(0, 255));
        pkt   = '{tag, 8'h00, 8'h00, total[15:8], total[7:0]};
        add_payload($urandom_range(0, 3));
        send_packet();
      end
    end
    wait_quiet();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    next_seq    = '0;
    msg_total   = '0;
    msg_filled  = '0;
    open_tag    = '0;
    hdr_hold    = '0;
    hdr_pos     = POS_TAG;
    pkt_verdict = V_OK;
    store_fill  = 0;
    fail_count  = 0;
    items_sent  = 0;
    burst_left  = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_item     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_max_message();
    test_random();

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
